/* src/sitda_pkg.sv */
// Shared types and constants for the signed integer to decimal text converter.
package sitda_pkg;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam int         POS_BITS   = 4;

endpackage

/* src/signed_int_to_decimal_ascii.sv */
// Top level: signed integer to decimal ASCII character stream.
//
// Usage notes:
//  - Slave channel s_axis_*: one signed integer per item in tdata.
//  - Master channel m_axis_*: one ASCII character per item, most significant
//    first; '-' leads a negative number, leading zeros are dropped and zero
//    gives a single '0'. tuser holds the 1-based position, tlast the final one.
//  - Front end: a register stage for sign/magnitude, the converter's input
//    register, then VALUE_BITS double-dabble stages, one shift each. A new
//    number may enter every cycle unless the pipeline is full and stalled.
//  - Throughput: one character per cycle while m_axis_tready is high;
//    each number is 1 to 11 characters at 32 bits.
//  - The serialiser takes the next number in the cycle its last character
//    leaves, so runs follow back to back.
//  - Reset clears all valid bits; nothing is in flight afterwards.
//  - When m_axis_tready is low the serialiser holds; bubbles in the pipeline
//    are still squeezed out so the front end keeps taking numbers until full.
module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] character
    output logic [3:0]  m_axis_tuser,   // [3:0] position
    output logic        m_axis_tlast
);
    // digits needed for 2^(VALUE_BITS-1): ceil(VALUE_BITS*log10 2)
    localparam int DIGITS = (VALUE_BITS * 30103 + 99999) / 100000;

    logic                  r_v;
    logic                  r_neg;
    logic [VALUE_BITS-1:0] r_mag;
    logic                  s_rdy;
    logic                  b_valid, b_neg, e_ready;
    logic [4*DIGITS-1:0]   b_bcd;
    logic [VALUE_BITS-1:0] n_raw;

    // low VALUE_BITS of the input, then magnitude as unsigned
    assign n_raw = VALUE_BITS'(s_axis_tdata);
    assign s_axis_tready = s_rdy || !r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (s_axis_tready) begin
            r_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready) begin
            r_neg <= n_raw[VALUE_BITS-1];
            r_mag <= n_raw[VALUE_BITS-1] ? (~n_raw + 1'b1) : n_raw;
        end
    end

    sitda_bcd #(.VALUE_BITS(VALUE_BITS), .DIGITS(DIGITS)) u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v),
        .o_ready (s_rdy),
        .i_mag   (r_mag),
        .i_neg   (r_neg),
        .o_valid (b_valid),
        .i_ready (e_ready),
        .o_bcd   (b_bcd),
        .o_neg   (b_neg)
    );

    sitda_emit #(.DIGITS(DIGITS)) u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (b_valid),
        .o_ready (e_ready),
        .i_bcd   (b_bcd),
        .i_neg   (b_neg),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_char  (m_axis_tdata),
        .o_pos   (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );
endmodule

/* src/sitda_bcd.sv */
// Pipelined binary to BCD conversion: an input register, then one double-dabble shift per stage.
module sitda_bcd #(
    parameter int VALUE_BITS = 32,
    parameter int DIGITS     = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [VALUE_BITS-1:0]   i_mag,
    input  logic                    i_neg,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [4*DIGITS-1:0]     o_bcd,
    output logic                    o_neg
);
    localparam int W = 4*DIGITS + VALUE_BITS;

    logic [VALUE_BITS:0] r_v;
    logic [W-1:0]        r_d   [VALUE_BITS+1];
    logic                r_n   [VALUE_BITS+1];
    logic [VALUE_BITS:0] adv;

    // stage 0 is the input register; stage k has done k shifts
    always_comb begin
        adv[VALUE_BITS] = i_ready || !r_v[VALUE_BITS];
        for (int k = VALUE_BITS - 1; k >= 0; k--) begin
            adv[k] = adv[k+1] || !r_v[k];
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[VALUE_BITS];
    assign o_bcd   = r_d[VALUE_BITS][W-1 -: 4*DIGITS];
    assign o_neg   = r_n[VALUE_BITS];

    function automatic logic [W-1:0] dabble(input logic [W-1:0] x);
        logic [W-1:0] y;
        y = x;
        for (int j = 0; j < DIGITS; j++) begin
            if (y[VALUE_BITS + 4*j +: 4] > 4'd4) begin
                y[VALUE_BITS + 4*j +: 4] = y[VALUE_BITS + 4*j +: 4] + 4'd3;
            end
        end
        return {y[W-2:0], 1'b0};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (adv[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k <= VALUE_BITS; k++) begin
                if (adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_d[0] <= {{(4*DIGITS){1'b0}}, i_mag};
            r_n[0] <= i_neg;
        end
        for (int k = 1; k <= VALUE_BITS; k++) begin
            if (adv[k]) begin
                r_d[k] <= dabble(r_d[k-1]);
                r_n[k] <= r_n[k-1];
            end
        end
    end
endmodule

/* src/sitda_emit.sv */
// Serialiser: sign, then significant BCD digits, one per cycle while i_ready.
module sitda_emit #(
    parameter int DIGITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [4*DIGITS-1:0]  i_bcd,
    input  logic                 i_neg,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [7:0]           o_char,
    output logic [sitda_pkg::POS_BITS-1:0] o_pos,
    output logic                 o_last
);
    localparam int IW = $clog2(DIGITS + 1);

    logic                r_busy;
    logic [4*DIGITS-1:0] r_bcd;
    logic                r_sign;
    logic [IW-1:0]       r_idx;
    logic [sitda_pkg::POS_BITS-1:0] r_pos;
    logic [IW-1:0]       top;
    logic                o_fire;

    // index of the highest non-zero digit, zero if all zero
    always_comb begin
        top = '0;
        for (int j = 0; j < DIGITS; j++) begin
            if (i_bcd[4*j +: 4] != 4'd0) begin
                top = IW'(j);
            end
        end
    end

    assign o_valid = r_busy;
    assign o_fire  = r_busy && i_ready;
    assign o_ready = !r_busy || (o_fire && o_last);
    assign o_char  = r_sign ? sitda_pkg::CHAR_MINUS
                            : (sitda_pkg::CHAR_ZERO | {4'd0, r_bcd[4*r_idx +: 4]});
    assign o_last  = !r_sign && (r_idx == '0);
    assign o_pos   = r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_ready) begin
            r_busy <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_bcd  <= i_bcd;
            r_sign <= i_neg;
            r_idx  <= top;
            r_pos  <= sitda_pkg::POS_BITS'(1);
        end else if (o_fire) begin
            r_pos <= r_pos + 1'b1;
            if (r_sign) begin
                r_sign <= 1'b0;
            end else begin
                r_idx <= r_idx - 1'b1;
            end
        end
    end
endmodule
